// ===== rtl/ttot_pkg.sv =====
package ttot_pkg;

   localparam int NUM_STAGES      = 4;
   localparam int STAGE_SETUP     = 0;
   localparam int STAGE_PRODUCT   = 1;
   localparam int STAGE_RANGE     = 2;
   localparam int STAGE_RESULT    = 3;
   localparam int RSP_TDATA_WIDTH = 8;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

endpackage

// ===== rtl/ttot_pipe_ctrl.sv =====
module ttot_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ttot_pkg::pipe_ctrl_type ctrl
);
   import ttot_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[STAGE_RESULT] = !valid_ff[STAGE_RESULT] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (en[STAGE_SETUP]) begin
         valid_in[STAGE_SETUP] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en     = en;
   assign req_tready  = en[STAGE_SETUP];
   assign rsp_tvalid  = valid_ff[STAGE_RESULT];

endmodule

// ===== rtl/ttot_edge_axis.sv =====
module ttot_edge_axis #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  ttot_pkg::pipe_ctrl_type        ctrl,
   input  logic signed [COORD_WIDTH-1:0] sx,
   input  logic signed [COORD_WIDTH-1:0] sy,
   input  logic signed [COORD_WIDTH-1:0] ex,
   input  logic signed [COORD_WIDTH-1:0] ey,
   input  logic signed [COORD_WIDTH-1:0] ox,
   input  logic signed [COORD_WIDTH-1:0] oy,
   input  logic signed [COORD_WIDTH-1:0] rect_left,
   input  logic signed [COORD_WIDTH-1:0] rect_right,
   input  logic signed [COORD_WIDTH-1:0] rect_top,
   input  logic signed [COORD_WIDTH-1:0] rect_bottom,
   output logic                          separates
);
   import ttot_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [DW-1:0] nx_in, ny_in, dl_in, dr_in, dt_in, db_in, dox_in, doy_in;
   logic signed [DW-1:0] nx_ff, ny_ff, dl_ff, dr_ff, dt_ff, db_ff, dox_ff, doy_ff;
   logic signed [PW-1:0] pl_in, pr_in, pt_in, pb_in, qx_in, qy_in;
   logic signed [PW-1:0] pl_ff, pr_ff, pt_ff, pb_ff, qx_ff, qy_ff;
   logic signed [PW-1:0] xmin, xmax, ymin, ymax;
   logic signed [SW-1:0] rmin_in, rmax_in, q1_in;
   logic signed [SW-1:0] rmin_ff, rmax_ff, q1_ff;
   logic signed [SW-1:0] tmin, tmax;

   // setup: edge normal and offsets from the start vertex
   assign nx_in  = DW'(sy) - DW'(ey);
   assign ny_in  = DW'(ex) - DW'(sx);
   assign dl_in  = DW'(rect_left) - DW'(sx);
   assign dr_in  = DW'(rect_right) - DW'(sx);
   assign dt_in  = DW'(rect_top) - DW'(sy);
   assign db_in  = DW'(rect_bottom) - DW'(sy);
   assign dox_in = DW'(ox) - DW'(sx);
   assign doy_in = DW'(oy) - DW'(sy);

   always_ff @(posedge clock) begin
      if (ctrl.en[STAGE_SETUP]) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         dl_ff  <= dl_in;
         dr_ff  <= dr_in;
         dt_ff  <= dt_in;
         db_ff  <= db_in;
         dox_ff <= dox_in;
         doy_ff <= doy_in;
      end
   end

   assign pl_in = PW'(dl_ff) * PW'(nx_ff);
   assign pr_in = PW'(dr_ff) * PW'(nx_ff);
   assign pt_in = PW'(dt_ff) * PW'(ny_ff);
   assign pb_in = PW'(db_ff) * PW'(ny_ff);
   assign qx_in = PW'(dox_ff) * PW'(nx_ff);
   assign qy_in = PW'(doy_ff) * PW'(ny_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[STAGE_PRODUCT]) begin
         pl_ff <= pl_in;
         pr_ff <= pr_in;
         pt_ff <= pt_in;
         pb_ff <= pb_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
   end

   // corner range splits into independent x and y terms
   assign xmin = (pl_ff < pr_ff) ? pl_ff : pr_ff;
   assign xmax = (pl_ff > pr_ff) ? pl_ff : pr_ff;
   assign ymin = (pt_ff < pb_ff) ? pt_ff : pb_ff;
   assign ymax = (pt_ff > pb_ff) ? pt_ff : pb_ff;

   assign rmin_in = SW'(xmin) + SW'(ymin);
   assign rmax_in = SW'(xmax) + SW'(ymax);
   assign q1_in   = SW'(qx_ff) + SW'(qy_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[STAGE_RANGE]) begin
         rmin_ff <= rmin_in;
         rmax_ff <= rmax_in;
         q1_ff   <= q1_in;
      end
   end

   // end vertex projects to zero on its own edge normal
   assign tmin = (q1_ff < 0) ? q1_ff : '0;
   assign tmax = (q1_ff > 0) ? q1_ff : '0;

   assign separates = (tmax < rmin_ff) || (tmin > rmax_ff);

endmodule

// ===== rtl/triangle_tile_overlap_test_unit.sv =====
// Channel  Direction  Handshake              Payload (tdata, lowest bits first)
// req      in         req_tvalid/req_tready  ax ay bx by cx cy rect_left rect_right
//                                            rect_top rect_bottom, COORD_WIDTH each
// rsp      out        rsp_tvalid/rsp_tready  overlaps in bit 0
//
// One test per cycle sustained while rsp is not stalled; each result passes
// from its accepted transaction through four register stages: setup, products,
// interval range, output register.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stall on rsp holds each full stage with no empty stage after it; empty stages
// keep filling, so no transaction is lost or repeated.
module triangle_tile_overlap_test_unit #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // ax, ay, bx, by, cx, cy, rect_left, rect_right, rect_top, rect_bottom
   input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // overlaps
   output logic [ttot_pkg::RSP_TDATA_WIDTH-1:0]     rsp_tdata
);
   import ttot_pkg::*;

   localparam int W = COORD_WIDTH;

   pipe_ctrl_type ctrl;

   logic signed [W-1:0] ax, ay, bx, by, cx, cy;
   logic signed [W-1:0] rect_left, rect_right, rect_top, rect_bottom;
   logic signed [W-1:0] bl, br, bt, bb;
   logic                miss_in;
   logic                miss_s0_ff, miss_s1_ff, miss_s2_ff;
   logic                sep_ab, sep_bc, sep_ca;
   logic                overlaps_in, overlaps_ff;

   assign ax          = req_tdata[0*W +: W];
   assign ay          = req_tdata[1*W +: W];
   assign bx          = req_tdata[2*W +: W];
   assign by          = req_tdata[3*W +: W];
   assign cx          = req_tdata[4*W +: W];
   assign cy          = req_tdata[5*W +: W];
   assign rect_left   = req_tdata[6*W +: W];
   assign rect_right  = req_tdata[7*W +: W];
   assign rect_top    = req_tdata[8*W +: W];
   assign rect_bottom = req_tdata[9*W +: W];

   ttot_pipe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   always_comb begin
      bl = (ax < bx) ? ax : bx;
      bl = (bl < cx) ? bl : cx;
      br = (ax > bx) ? ax : bx;
      br = (br > cx) ? br : cx;
      bt = (ay < by) ? ay : by;
      bt = (bt < cy) ? bt : cy;
      bb = (ay > by) ? ay : by;
      bb = (bb > cy) ? bb : cy;
   end

   assign miss_in = (br < rect_left) || (bl > rect_right) ||
                    (bb < rect_top) || (bt > rect_bottom);

   always_ff @(posedge clock) begin
      if (ctrl.en[STAGE_SETUP]) begin
         miss_s0_ff <= miss_in;
      end
      if (ctrl.en[STAGE_PRODUCT]) begin
         miss_s1_ff <= miss_s0_ff;
      end
      if (ctrl.en[STAGE_RANGE]) begin
         miss_s2_ff <= miss_s1_ff;
      end
      if (ctrl.en[STAGE_RESULT]) begin
         overlaps_ff <= overlaps_in;
      end
   end

   ttot_edge_axis #(.COORD_WIDTH(W)) u_edge_ab (
      .clock       (clock),
      .ctrl        (ctrl),
      .sx          (ax),
      .sy          (ay),
      .ex          (bx),
      .ey          (by),
      .ox          (cx),
      .oy          (cy),
      .rect_left   (rect_left),
      .rect_right  (rect_right),
      .rect_top    (rect_top),
      .rect_bottom (rect_bottom),
      .separates   (sep_ab)
   );

   ttot_edge_axis #(.COORD_WIDTH(W)) u_edge_bc (
      .clock       (clock),
      .ctrl        (ctrl),
      .sx          (bx),
      .sy          (by),
      .ex          (cx),
      .ey          (cy),
      .ox          (ax),
      .oy          (ay),
      .rect_left   (rect_left),
      .rect_right  (rect_right),
      .rect_top    (rect_top),
      .rect_bottom (rect_bottom),
      .separates   (sep_bc)
   );

   ttot_edge_axis #(.COORD_WIDTH(W)) u_edge_ca (
      .clock       (clock),
      .ctrl        (ctrl),
      .sx          (cx),
      .sy          (cy),
      .ex          (ax),
      .ey          (ay),
      .ox          (bx),
      .oy          (by),
      .rect_left   (rect_left),
      .rect_right  (rect_right),
      .rect_top    (rect_top),
      .rect_bottom (rect_bottom),
      .separates   (sep_ca)
   );

   assign overlaps_in = !(miss_s2_ff || sep_ab || sep_bc || sep_ca);

   assign rsp_tdata = {{(RSP_TDATA_WIDTH-1){1'b0}}, overlaps_ff};

endmodule

// ===== rtl/ttot_checker.sv =====
module ttot_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [ttot_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import ttot_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output register");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without downstream backpressure");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_WIDTH-1:1] == '0)
      else $error("rsp_tdata padding not zero");

endmodule

bind triangle_tile_overlap_test_unit ttot_checker u_ttot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
